// File: rtl/core/kgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgm_pkg
// shared constants and types of the kruskal maze generator
// ----------------------------------------------------------------------------
package kgm_pkg;

  localparam int unsigned MaxRowsDef    = 16;
  localparam int unsigned MaxColumnsDef = 16;

  localparam int unsigned WeightW  = 7;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned RowIdxW  = 4;
  localparam int unsigned MaskW    = 16;

  localparam logic [WeightW-1:0] WeightMax = '1;

  localparam logic [CfgIdxW-1:0] CFG_ROWS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLUMNS = 2'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_WREAD,
    ST_WCMP,
    ST_FREAD,
    ST_FCHK,
    ST_EMIT
  } kgm_state_e;

endpackage

// File: rtl/core/kgm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgm_in_if
// edge weight request channel
// ----------------------------------------------------------------------------
interface kgm_in_if;
  logic                         valid;
  logic                         ready;
  logic [kgm_pkg::WeightW-1:0]  edge_weight;

  modport source (output valid, output edge_weight, input ready);
  modport sink   (input valid, input edge_weight, output ready);
endinterface

// File: rtl/core/kgm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgm_out_if
// maze row request channel
// ----------------------------------------------------------------------------
interface kgm_out_if;
  logic                         valid;
  logic                         ready;
  logic [kgm_pkg::RowIdxW-1:0]  row_index;
  logic [kgm_pkg::MaskW-1:0]    open_right;
  logic [kgm_pkg::MaskW-1:0]    open_down;
  logic                         last_row;

  modport source (output valid, output row_index, output open_right, output open_down,
                  output last_row, input ready);
  modport sink   (input valid, input row_index, input open_right, input open_down,
                  input last_row, output ready);
endinterface

// File: rtl/core/kruskal_grid_maze_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_grid_maze_generator_core
// kruskal maze generation with union-find over weight and parent memories
// ----------------------------------------------------------------------------
// load: one edge weight request per cycle into the weight memory
// build: 128 passes over the edges in load order, one pass per weight value;
//   each edge weight is read and compared, and on a match the roots of both
//   cells are searched by parent hops; differing roots open the passage
// emit: one row request per cycle while the receiver is ready, then the maze state is cleared
// reset: rows and columns 16, no edges loaded, all cells their own root
// ----------------------------------------------------------------------------
module kruskal_grid_maze_generator_core #(
  parameter int unsigned MAX_ROWS    = kgm_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLUMNS = kgm_pkg::MaxColumnsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kgm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kgm_pkg::CfgW-1:0]      cfg_wdata_i,
  kgm_in_if.sink                        edge_i,
  kgm_out_if.source                     row_o
);
  import kgm_pkg::*;

  localparam int unsigned RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW      = $clog2(MAX_COLUMNS);
  localparam int unsigned RCW     = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW     = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CellCap = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned CellW   = $clog2(CellCap);
  localparam int unsigned EdgeCap = 2 * MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned EAW     = $clog2(EdgeCap);
  localparam int unsigned ECW     = $clog2(EdgeCap + 1);

  // configuration
  logic [CfgW-1:0] rows_cfg_q, cols_cfg_q;
  logic [RCW-1:0]  rows_use;
  logic [CCW-1:0]  cols_use;
  logic [ECW-1:0]  total_edges;

  always_comb begin
    if (rows_cfg_q == '0) rows_use = RCW'(1);
    else if (32'(rows_cfg_q) > MAX_ROWS) rows_use = RCW'(MAX_ROWS);
    else rows_use = RCW'(rows_cfg_q);
    if (cols_cfg_q < CfgW'(2)) cols_use = CCW'(2);
    else if (32'(cols_cfg_q) > MAX_COLUMNS) cols_use = CCW'(MAX_COLUMNS);
    else cols_use = CCW'(cols_cfg_q);
  end

  // rows*(cols-1) + (rows-1)*cols
  assign total_edges = ECW'(2 * 32'(rows_use) * 32'(cols_use) - 32'(rows_use)
                            - 32'(cols_use));

  // state
  kgm_state_e state_q, state_d;
  logic [ECW-1:0]     load_cnt_q, load_cnt_d;
  logic [WeightW-1:0] w_q, w_d;
  logic [EAW-1:0]     e_q, e_d;
  logic [RW-1:0]      i_q, i_d;
  logic [CW-1:0]      j_q, j_d;
  logic [CellW-1:0]   cell_q, cell_d;
  logic               dir_q, dir_d;        // 0 right edge, 1 down edge
  logic [CellW-1:0]   x_q, x_d, ra_q, ra_d;
  logic               phase_b_q, phase_b_d;
  logic [RW-1:0]      row_q, row_d;

  logic [MAX_COLUMNS-1:0] right_q [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] down_q  [MAX_ROWS];
  logic [CellCap-1:0]     pvalid_q;

  // memories
  logic [WeightW-1:0] wmem [EdgeCap];
  logic [CellW-1:0]   pmem [CellCap];
  logic [WeightW-1:0] wdata_q;
  logic [CellW-1:0]   pdata_q;
  logic               pdata_valid_q;

  logic in_acc, out_acc, cfg_hit, clear_maze;
  logic load_last, last_edge, last_emit;
  logic merge_we, root_hit;
  logic [CellW-1:0] b_cell, parent_of_x;
  logic [RW-1:0] ni;
  logic [CW-1:0] nj;
  logic [CellW-1:0] ncell;
  logic ndir;

  assign in_acc    = edge_i.valid && edge_i.ready;
  assign out_acc   = row_o.valid && row_o.ready;
  assign cfg_hit   = cfg_we_i && (cfg_idx_i == CFG_ROWS || cfg_idx_i == CFG_COLUMNS);
  assign load_last = (load_cnt_q + ECW'(1)) == total_edges;
  assign last_edge = (ECW'(e_q) + ECW'(1)) == total_edges;
  assign last_emit = (RCW'(row_q) + RCW'(1)) == rows_use;
  assign clear_maze = cfg_hit || (out_acc && last_emit);

  assign b_cell      = dir_q ? cell_q + CellW'(cols_use) : cell_q + CellW'(1);
  assign parent_of_x = pdata_valid_q ? pdata_q : x_q;
  assign root_hit    = parent_of_x == x_q;
  // second root found in a different set: open the passage
  assign merge_we    = (state_q == ST_FCHK) && root_hit && phase_b_q && (ra_q != x_q);

  // next edge in load order
  always_comb begin
    ni = i_q; nj = j_q; ncell = cell_q + CellW'(1); ndir = 1'b0;
    if (!dir_q && (RCW'(i_q) + RCW'(1)) < rows_use) begin
      ndir  = 1'b1;
      ncell = cell_q;
    end else begin
      if ((CCW'(j_q) + CCW'(1)) < cols_use) begin
        nj = j_q + CW'(1);
      end else begin
        nj = '0;
        ni = i_q + RW'(1);
      end
      ndir = !((CCW'(nj) + CCW'(1)) < cols_use);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && load_last) state_d = ST_WREAD;
      ST_WREAD: state_d = ST_WCMP;
      ST_WCMP: begin
        if (wdata_q == w_q) state_d = ST_FREAD;
        else if (last_edge && w_q == WeightMax) state_d = ST_EMIT;
        else state_d = ST_WREAD;
      end
      ST_FREAD: state_d = ST_FCHK;
      ST_FCHK: begin
        if (!root_hit || !phase_b_q) state_d = ST_FREAD;
        else if (last_edge && w_q == WeightMax) state_d = ST_EMIT;
        else state_d = ST_WREAD;
      end
      ST_EMIT:  if (out_acc && last_emit) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
    if (cfg_hit) state_d = ST_LOAD;
  end

  // datapath
  always_comb begin
    logic advance;
    advance    = 1'b0;
    load_cnt_d = load_cnt_q;
    w_d = w_q; e_d = e_q; i_d = i_q; j_d = j_q; cell_d = cell_q; dir_d = dir_q;
    x_d = x_q; ra_d = ra_q; phase_b_d = phase_b_q; row_d = row_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          load_cnt_d = load_last ? '0 : load_cnt_q + ECW'(1);
          if (load_last) begin
            w_d = '0; e_d = '0; i_d = '0; j_d = '0; cell_d = '0; dir_d = 1'b0;
          end
        end
      end
      ST_WCMP: begin
        if (wdata_q == w_q) begin
          x_d = cell_q;
          phase_b_d = 1'b0;
        end else begin
          advance = 1'b1;
        end
      end
      ST_FCHK: begin
        if (!root_hit) begin
          x_d = parent_of_x;
        end else if (!phase_b_q) begin
          ra_d = x_q;
          x_d = b_cell;
          phase_b_d = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      ST_EMIT: if (out_acc) row_d = last_emit ? '0 : row_q + RW'(1);
      default: ;
    endcase
    if (advance) begin
      if (last_edge) begin
        // end of one weight pass
        w_d = w_q + WeightW'(1);
        e_d = '0; i_d = '0; j_d = '0; cell_d = '0; dir_d = 1'b0;
        row_d = '0;
      end else begin
        e_d = e_q + EAW'(1); i_d = ni; j_d = nj; cell_d = ncell; dir_d = ndir;
      end
    end
    if (cfg_hit) begin
      load_cnt_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      rows_cfg_q <= CfgW'(16);
      cols_cfg_q <= CfgW'(16);
      load_cnt_q <= '0;
      w_q <= '0; e_q <= '0; i_q <= '0; j_q <= '0; cell_q <= '0; dir_q <= 1'b0;
      x_q <= '0; ra_q <= '0; phase_b_q <= 1'b0; row_q <= '0;
      pvalid_q <= '0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        right_q[r] <= '0;
        down_q[r]  <= '0;
      end
    end else begin
      state_q <= state_d;
      load_cnt_q <= load_cnt_d;
      w_q <= w_d; e_q <= e_d; i_q <= i_d; j_q <= j_d; cell_q <= cell_d; dir_q <= dir_d;
      x_q <= x_d; ra_q <= ra_d; phase_b_q <= phase_b_d; row_q <= row_d;
      if (cfg_we_i && cfg_idx_i == CFG_ROWS) rows_cfg_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CFG_COLUMNS) cols_cfg_q <= cfg_wdata_i;
      if (clear_maze) begin
        pvalid_q <= '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
          right_q[r] <= '0;
          down_q[r]  <= '0;
        end
      end else if (merge_we) begin
        pvalid_q[ra_q] <= 1'b1;
        if (dir_q) down_q[i_q][j_q]  <= 1'b1;
        else       right_q[i_q][j_q] <= 1'b1;
      end
    end
  end

  // weight memory: write on load, read at current edge
  always_ff @(posedge clk_i) begin
    if (in_acc) wmem[load_cnt_q[EAW-1:0]] <= edge_i.edge_weight;
    wdata_q <= wmem[e_q];
  end

  // parent memory: entries without a valid bit read as their own cell
  always_ff @(posedge clk_i) begin
    if (merge_we) pmem[ra_q] <= x_q;
    pdata_q       <= pmem[x_q];
    pdata_valid_q <= pvalid_q[x_q];
  end

  assign edge_i.ready     = state_q == ST_LOAD;
  assign row_o.valid      = state_q == ST_EMIT;
  assign row_o.row_index  = RowIdxW'(row_q);
  assign row_o.open_right = MaskW'(right_q[row_q]);
  assign row_o.open_down  = MaskW'(down_q[row_q]);
  assign row_o.last_row   = last_emit;

  // never take an edge while a row is still offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(edge_i.ready && row_o.valid)) else $error("load and emit overlap");

  // emitted row stays inside the configured grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_o.valid |-> (RCW'(row_q) < rows_use)) else $error("row out of range");

  // final row taken returns to loading with an empty maze
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_emit) |=> (edge_i.ready && pvalid_q == '0))
    else $error("maze not cleared after emit");

endmodule

// File: sim/tb_kruskal_grid_maze_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_grid_maze_generator_core
// self-checking bench for the kruskal maze generator core
// ----------------------------------------------------------------------------
// loads edge weights for many small grids and a few extreme ones, predicts
// each maze by kruskal with union-find and compares every row request field
// by field; covers clamped sizes, ties, abandoned loads and ignored writes
// ----------------------------------------------------------------------------
module tb_kruskal_grid_maze_generator_core;
  import kgm_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned SettleCycles = 600;

  typedef struct packed {
    logic [RowIdxW-1:0] row_index;
    logic [MaskW-1:0]   open_right;
    logic [MaskW-1:0]   open_down;
    logic               last_row;
  } maze_row_t;

  // tracks loaded weights and predicts the maze rows
  class maze_scoreboard;
    logic [CfgW-1:0]    rows_reg = 5'd16;
    logic [CfgW-1:0]    cols_reg = 5'd16;
    logic [WeightW-1:0] weights[$];
    maze_row_t          rows_due[$];
    int                 errors = 0;
    int                 mazes = 0;
    int                 rows_seen = 0;

    function int rows_used();
      return (rows_reg < 1) ? 1 : (rows_reg > 16) ? 16 : int'(rows_reg);
    endfunction

    function int cols_used();
      return (cols_reg < 2) ? 2 : (cols_reg > 16) ? 16 : int'(cols_reg);
    endfunction

    function int edge_total();
      int r;
      int c;
      r = rows_used();
      c = cols_used();
      return r * (c - 1) + (r - 1) * c;
    endfunction

    function void set_config(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      if (idx == CFG_ROWS) rows_reg = val;
      else if (idx == CFG_COLUMNS) cols_reg = val;
      else return;
      // any accepted register write restarts the load
      weights.delete();
    endfunction

    function void build_maze();
      int r;
      int c;
      int n;
      int ea[512];
      int eb[512];
      bit edown[512];
      int parent[256];
      int ra;
      int rb;
      logic [MaskW-1:0] right_m[16];
      logic [MaskW-1:0] down_m[16];
      maze_row_t row;
      r = rows_used();
      c = cols_used();
      n = 0;
      for (int i = 0; i < r; i++) begin
        for (int j = 0; j < c; j++) begin
          if (j + 1 < c) begin
            ea[n] = i * c + j; eb[n] = i * c + j + 1; edown[n] = 0; n++;
          end
          if (i + 1 < r) begin
            ea[n] = i * c + j; eb[n] = (i + 1) * c + j; edown[n] = 1; n++;
          end
        end
      end
      for (int k = 0; k < 256; k++) parent[k] = k;
      for (int k = 0; k < 16; k++) begin
        right_m[k] = '0;
        down_m[k] = '0;
      end
      // ascending weight, ties by load order
      for (int w = 0; w < 128; w++) begin
        for (int e = 0; e < n; e++) begin
          if (weights[e] == w) begin
            ra = ea[e];
            while (parent[ra] != ra) ra = parent[ra];
            rb = eb[e];
            while (parent[rb] != rb) rb = parent[rb];
            if (ra != rb) begin
              if (edown[e]) down_m[ea[e] / c][ea[e] % c] = 1'b1;
              else right_m[ea[e] / c][ea[e] % c] = 1'b1;
              parent[ra] = rb;
            end
          end
        end
      end
      for (int i = 0; i < r; i++) begin
        row.row_index  = i[RowIdxW-1:0];
        row.open_right = right_m[i];
        row.open_down  = down_m[i];
        row.last_row   = (i + 1 == r);
        rows_due = {rows_due, row};
      end
      weights.delete();
      mazes++;
    endfunction

    function void note_weight(logic [WeightW-1:0] w);
      weights = {weights, w};
      if (weights.size() == edge_total()) build_maze();
    endfunction

    function void check_row(maze_row_t got);
      maze_row_t want;
      rows_seen++;
      if (rows_due.size() == 0) begin
        $error("row request with nothing expected: row_index %0d", got.row_index);
        errors++;
        return;
      end
      want = rows_due.pop_front();
      if (got.row_index !== want.row_index) begin
        $error("row_index expected %0d actual %0d", want.row_index, got.row_index);
        errors++;
      end
      if (got.open_right !== want.open_right) begin
        $error("open_right expected %h actual %h", want.open_right, got.open_right);
        errors++;
      end
      if (got.open_down !== want.open_down) begin
        $error("open_down expected %h actual %h", want.open_down, got.open_down);
        errors++;
      end
      if (got.last_row !== want.last_row) begin
        $error("last_row expected %0d actual %0d", want.last_row, got.last_row);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;

  kgm_in_if  edge_if ();
  kgm_out_if row_if ();

  kruskal_grid_maze_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_if),
    .row_o       (row_if)
  );

  maze_scoreboard maze_sb = new();

  // idle percentages of the weight sender and the row receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int weights_sent = 0;
  int unsigned cycle_count = 0;

  always #2 clk_i = ~clk_i;

  // cycle counter guards against a hung block
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // row receiver: check on each handshake, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && row_if.valid && row_if.ready) begin
      maze_sb.check_row({row_if.row_index, row_if.open_right, row_if.open_down,
                         row_if.last_row});
    end
    row_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one weight request; valid stays high between back-to-back requests
  task automatic send_weight(input logic [WeightW-1:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      edge_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    edge_if.valid <= 1'b1;
    edge_if.edge_weight <= w;
    do @(posedge clk_i); while (!edge_if.ready);
    maze_sb.note_weight(w);
    weights_sent++;
  endtask

  // let every expected row drain and the block settle before a write
  task automatic wait_quiet();
    edge_if.valid <= 1'b0;
    while (maze_sb.rows_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    maze_sb.set_config(idx, val);
  endtask

  task automatic set_grid(input logic [CfgW-1:0] r, input logic [CfgW-1:0] c);
    wait_quiet();
    write_reg(CFG_ROWS, r);
    write_reg(CFG_COLUMNS, c);
  endtask

  function automatic logic [WeightW-1:0] WeightWTrunc(input int unsigned v);
    return v[WeightW-1:0];
  endfunction

  // one full maze; style 0 full 7-bit range, 1 range 0 to 100, 2 heavy ties
  task automatic load_maze(input int style);
    int n;
    n = maze_sb.edge_total();
    for (int k = 0; k < n; k++) begin
      case (style)
        0: send_weight(WeightWTrunc($urandom_range(127)));
        1: send_weight(WeightWTrunc($urandom_range(100)));
        default: send_weight(WeightWTrunc($urandom_range(3)));
      endcase
    end
  endtask

  initial begin
    int target;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_ROWS;
    cfg_wdata_i <= '0;
    edge_if.valid <= 1'b0;
    edge_if.edge_weight <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest grid, lowest weight
    set_grid(5'd1, 5'd2);
    send_weight(7'd0);
    // clamped sizes: zero rows and one column become a 1x2 grid
    set_grid(5'd0, 5'd1);
    send_weight(WeightMax);
    // 2x2 with all weights tied, then strictly falling weights
    set_grid(5'd2, 5'd2);
    repeat (4) send_weight(7'd5);
    send_weight(7'd127); send_weight(7'd100); send_weight(7'd64); send_weight(7'd0);
    // writes to unused indexes leave a partial load alone
    send_weight(7'd42); send_weight(7'd85);
    wait_quiet();
    write_reg(CFG_SPARE_B, 5'd31);
    write_reg(CFG_SPARE_A, 5'd0);
    send_weight(7'd1); send_weight(7'd2);
    // a real register write abandons the partial load
    send_weight(7'd99);
    wait_quiet();
    write_reg(CFG_COLUMNS, 5'd2);
    send_weight(7'd3); send_weight(7'd3); send_weight(7'd2); send_weight(7'd2);

    // oversized values clamp to the largest grid dimension
    set_grid(5'd31, 5'd2);
    load_maze(0);
    set_grid(5'd1, 5'd31);
    load_maze(1);
    set_grid(5'd2, 5'd16);
    load_maze(2);

    // random mazes under three idle profiles
    for (int ph = 0; ph < 3; ph++) begin
      wait_quiet();
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 9 : 0;
      target = weights_sent + 88;
      while (weights_sent < target) begin
        if ($urandom_range(9) == 0)
          set_grid(CfgW'($urandom_range(1, 16)), CfgW'($urandom_range(2, 8)));
        else
          set_grid(CfgW'($urandom_range(1, 4)), CfgW'($urandom_range(2, 5)));
        if ($urandom_range(7) == 0) begin
          // broken sequence: partial load, then a restart by rewrite
          repeat ($urandom_range(1, maze_sb.edge_total() - 1 > 0 ?
                                    maze_sb.edge_total() - 1 : 0))
            send_weight(WeightWTrunc($urandom_range(127)));
          wait_quiet();
          write_reg(CFG_ROWS, maze_sb.rows_reg);
        end
        load_maze($urandom_range(2));
      end
    end

    wait_quiet();
    $display("covered %0d edge weights, %0d mazes, %0d rows checked",
             weights_sent, maze_sb.mazes, maze_sb.rows_seen);
    $display("grids from 1x2 to 16x16 clamps, ties, abandoned loads, three idle profiles");
    if (maze_sb.errors == 0 && maze_sb.rows_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kgm_pkg.sv
rtl/core/kgm_in_if.sv
rtl/core/kgm_out_if.sv
rtl/core/kruskal_grid_maze_generator_core.sv
sim/tb_kruskal_grid_maze_generator_core.sv
